### hw/rtl/slid_pkg.sv
// Shared types for the sorted list insert/delete block.
// Holds the status codes, the controller state type and the command and status
// structs that run between controller and datapath. No dependencies.
package slid_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W          = 32;
  localparam int COUNT_OUT_W      = 5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_FINISH
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic    load;        // latch op/value, preset index
    logic    set_status;
    status_t status_code;
    logic    idx_inc;
    logic    idx_dec;
    logic    set_found;
    logic    ram_we;
    logic    wr_value;    // write the operand instead of the read entry
    logic    count_inc;
    logic    count_dec;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_delete;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_at_count;
    logic found;
    logic rd_greater;     // read entry is greater than the operand
    logic rd_equal;       // read entry equals the operand
  } stat_t;

endpackage

### hw/rtl/slid_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the sorted entry table. No dependencies.
module slid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/slid_datapath.sv
// Datapath of the sorted list block: operand registers, index and count,
// the entry RAM and its compare logic. Depends on slid_pkg and slid_ram.
module slid_datapath #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               op,
  input  logic signed [slid_pkg::VALUE_W-1:0] value,
  input  slid_pkg::cmd_t                     cmd,
  output slid_pkg::stat_t                    stat,
  output logic [1:0]                         status,
  output logic [slid_pkg::COUNT_OUT_W-1:0]   count_after
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic                               op_r;
  logic signed [slid_pkg::VALUE_W-1:0] value_r;
  logic [CW-1:0]                      idx;
  logic [CW-1:0]                      idx_m1;
  logic [CW-1:0]                      count;
  logic                               found;
  slid_pkg::status_t                  status_r;
  logic [AW-1:0]                      raddr;
  logic [AW-1:0]                      waddr;
  logic [slid_pkg::VALUE_W-1:0]       wdata;
  logic [slid_pkg::VALUE_W-1:0]       rdata;
  logic [CW+slid_pkg::COUNT_OUT_W-1:0] count_ext;

  // Operand latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op;
      value_r <= value;
    end
  end

  // Scan index: insert walks down from the top, delete walks up from zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= op ? '0 : count;
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Entry count, match flag and result status
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      found    <= 1'b0;
      status_r <= slid_pkg::ST_DONE;
    end else begin
      if (cmd.count_inc) begin
        count <= count + 1'b1;
      end else if (cmd.count_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.load) begin
        found <= 1'b0;
      end else if (cmd.set_found) begin
        found <= 1'b1;
      end
      if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
    end
  end

  // Addresses: insert reads idx-1 and writes idx, delete reads idx and writes idx-1
  assign idx_m1 = idx - 1'b1;
  assign raddr  = op_r ? idx[AW-1:0] : idx_m1[AW-1:0];
  assign waddr  = op_r ? idx_m1[AW-1:0] : idx[AW-1:0];
  assign wdata  = cmd.wr_value ? value_r : rdata;

  slid_ram #(
    .WIDTH(slid_pkg::VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Status back to the controller
  always_comb begin
    stat.is_delete    = op_r;
    stat.full         = (count == CAP_C);
    stat.empty        = (count == '0);
    stat.idx_zero     = (idx == '0);
    stat.idx_at_count = (idx == count);
    stat.found        = found;
    stat.rd_greater   = (value_r < $signed(rdata));
    stat.rd_equal     = (rdata == value_r);
  end

  // Result fields; count is reported modulo the field width
  assign count_ext   = {{slid_pkg::COUNT_OUT_W{1'b0}}, count};
  assign count_after = count_ext[slid_pkg::COUNT_OUT_W-1:0];
  assign status      = status_r;

endmodule

### hw/rtl/slid_ctrl.sv
// Controller state machine of the sorted list block: sequences the scan and
// shift through the entry RAM. Depends on slid_pkg.
module slid_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  slid_pkg::stat_t stat,
  output slid_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  slid_pkg::state_t state;
  slid_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slid_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      slid_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = slid_pkg::S_CHECK;
        end
      end
      slid_pkg::S_CHECK: begin
        if (!stat.is_delete) begin
          if (stat.full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = slid_pkg::ST_FULL;
            state_next      = slid_pkg::S_FINISH;
          end else begin
            state_next = slid_pkg::S_INS_RD;
          end
        end else begin
          if (stat.empty) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = slid_pkg::ST_EMPTY;
            state_next      = slid_pkg::S_FINISH;
          end else begin
            state_next = slid_pkg::S_DEL_RD;
          end
        end
      end
      // Insert: bottom reached, place the operand at entry zero; else go on to the compare
      slid_pkg::S_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.ram_we      = 1'b1;
          cmd.wr_value    = 1'b1;
          cmd.count_inc   = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = slid_pkg::ST_DONE;
          state_next      = slid_pkg::S_FINISH;
        end else begin
          state_next = slid_pkg::S_INS_CMP;
        end
      end
      // Insert: move a greater entry up one slot, else drop the operand in
      slid_pkg::S_INS_CMP: begin
        cmd.ram_we = 1'b1;
        if (stat.rd_greater) begin
          cmd.idx_dec = 1'b1;
          state_next  = slid_pkg::S_INS_RD;
        end else begin
          cmd.wr_value    = 1'b1;
          cmd.count_inc   = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = slid_pkg::ST_DONE;
          state_next      = slid_pkg::S_FINISH;
        end
      end
      // Delete: end of table reached, finish; else go on to the compare
      slid_pkg::S_DEL_RD: begin
        if (stat.idx_at_count) begin
          cmd.set_status = 1'b1;
          if (stat.found) begin
            cmd.count_dec   = 1'b1;
            cmd.status_code = slid_pkg::ST_DONE;
          end else begin
            cmd.status_code = slid_pkg::ST_NOT_FOUND;
          end
          state_next = slid_pkg::S_FINISH;
        end else begin
          state_next = slid_pkg::S_DEL_CMP;
        end
      end
      // Delete: after the first match every entry moves down one slot
      slid_pkg::S_DEL_CMP: begin
        if (stat.found) begin
          cmd.ram_we = 1'b1;
        end else if (stat.rd_equal) begin
          cmd.set_found = 1'b1;
        end
        cmd.idx_inc = 1'b1;
        state_next  = slid_pkg::S_DEL_RD;
      end
      slid_pkg::S_FINISH: begin
        state_next = slid_pkg::S_IDLE;
      end
      default: begin
        state_next = slid_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != slid_pkg::S_IDLE);
  assign done = (state == slid_pkg::S_FINISH);

endmodule

### hw/rtl/sorted_list_insert_delete.sv
// Sorted table of signed values with insert and delete, one operation per transfer.
// A refused insert or an empty delete goes from the check straight to the finish state;
// an insert reads and compares each entry from the top down, moving greater ones up a slot,
// then writes the operand in; a delete reads, then compares, each stored entry in turn.
// One operation at a time; done marks the last cycle, the next is taken the cycle after.
// done is a one-cycle strobe the receiver cannot stall. Synchronous reset empties the table.
module sorted_list_insert_delete #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               op,
  input  logic signed [slid_pkg::VALUE_W-1:0] value,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [slid_pkg::COUNT_OUT_W-1:0]   count_after
);

  slid_pkg::cmd_t  cmd;
  slid_pkg::stat_t stat;

  slid_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  slid_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .status     (status),
    .count_after(count_after)
  );

endmodule

### tb/slid_checker.sv
// Checker for sorted_list_insert_delete: watches the command and result channels,
// keeps its own shadow of the sorted table and compares every result in order.
// Depends on slid_pkg for the status codes and field widths.
module slid_checker #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               op,
  input  logic signed [slid_pkg::VALUE_W-1:0] value,
  input  logic                               done,
  input  logic [1:0]                         status,
  input  logic [slid_pkg::COUNT_OUT_W-1:0]   count_after,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked,
  output int                                 full_hits,
  output int                                 empty_hits,
  output int                                 miss_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    slid_pkg::status_t                st;
    logic [slid_pkg::COUNT_OUT_W-1:0] cnt;
  } outcome_t;

  // Shadow copy of the table, ascending signed order
  logic signed [slid_pkg::VALUE_W-1:0] shadow_vals [CAPACITY];
  int                                  shadow_cnt;
  outcome_t                            expected_outcomes [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    full_hits  = 0;
    empty_hits = 0;
    miss_hits  = 0;
    shadow_cnt = 0;
  end

  // Apply one operation to the shadow table and return the outcome it gives
  function automatic outcome_t apply_operation(input logic is_del,
                                               input logic signed [slid_pkg::VALUE_W-1:0] v);
    outcome_t res;
    int       pos;
    res.st = slid_pkg::ST_DONE;
    pos    = 0;
    if (!is_del) begin
      if (shadow_cnt >= CAPACITY) begin
        res.st = slid_pkg::ST_FULL;
      end else begin
        // in front of the first entry that is not less than v
        while (pos < shadow_cnt && shadow_vals[pos] < v) pos++;
        for (int i = shadow_cnt; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = v;
        shadow_cnt++;
      end
    end else if (shadow_cnt == 0) begin
      res.st = slid_pkg::ST_EMPTY;
    end else begin
      while (pos < shadow_cnt && shadow_vals[pos] != v) pos++;
      if (pos >= shadow_cnt) begin
        res.st = slid_pkg::ST_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < shadow_cnt; i++) shadow_vals[i] = shadow_vals[i+1];
        shadow_cnt--;
      end
    end
    res.cnt = shadow_cnt[slid_pkg::COUNT_OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      shadow_cnt = 0;
      expected_outcomes.delete();
    end else begin
      // result side: compare against the oldest outstanding transfer
      if (done) begin
        got.st  = slid_pkg::status_t'(status);
        got.cnt = count_after;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with no transfer outstanding: status %0d count %0d",
                   $time, status, count_after);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          checked++;
          if (got.st !== want.st) begin
            $display("%0t: status mismatch: expected %0d (%s) actual %0d",
                     $time, want.st, want.st.name(), status);
            fail_count++;
          end
          if (got.cnt !== want.cnt) begin
            $display("%0t: count_after mismatch: expected %0d actual %0d",
                     $time, want.cnt, count_after);
            fail_count++;
          end
        end
      end
      // command side: predict on every accepted transfer
      if (start && !busy) begin
        want = apply_operation(op, value);
        case (want.st)
          slid_pkg::ST_FULL:      full_hits++;
          slid_pkg::ST_EMPTY:     empty_hits++;
          slid_pkg::ST_NOT_FOUND: miss_hits++;
          default:                ;
        endcase
        expected_outcomes.push_back(want);
      end
    end
    pending = expected_outcomes.size();
  end

endmodule

### tb/tb_sorted_list_insert_delete.sv
// Top of the sorted_list_insert_delete testbench: clock, reset and command stimulus.
// Directed corner cases first, then random insert/delete runs under several idle mixes.
// Depends on slid_pkg, the block itself and slid_checker.
module tb_sorted_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP   = 16;
  localparam int LIMIT = 400000;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic                                op;
  logic signed [slid_pkg::VALUE_W-1:0] value;
  logic                                done;
  logic [1:0]                          status;
  logic [slid_pkg::COUNT_OUT_W-1:0]    count_after;

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int empty_hits;
  int miss_hits;

  int          cycle_count = 0;
  int          idle_pct;
  int          n_ins = 0;
  int          n_del = 0;
  logic [31:0] value_pool [$];

  sorted_list_insert_delete #(.CAPACITY(CAP)) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .value      (value),
    .done       (done),
    .status     (status),
    .count_after(count_after)
  );

  slid_checker #(.CAPACITY(CAP)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .value      (value),
    .done       (done),
    .status     (status),
    .count_after(count_after),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .full_hits  (full_hits),
    .empty_hits (empty_hits),
    .miss_hits  (miss_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // One command transfer; called and returns at a falling edge
  task automatic send_op(input logic o, input logic [31:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    op    <= o;
    value <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (o) n_del++;
    else n_ins++;
  endtask

  // Mix of small values (duplicates), corners and full-range values
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 8) - 4;
    if (r < 45) begin
      case ($urandom_range(0, 5))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        3:       return 32'hffff_ffff;
        4:       return 32'h8000_0001;
        default: return 32'h7fff_fffe;
      endcase
    end
    return $urandom;
  endfunction

  // Runs of insert-heavy, delete-heavy and balanced traffic so the table fills and drains
  task automatic run_phase(input int pct, input int n_items);
    int          left;
    int          seg;
    int          bias;
    int          k;
    logic [31:0] v;
    idle_pct = pct;
    left     = n_items;
    while (left > 0) begin
      seg = $urandom_range(8, 48);
      if (seg > left) seg = left;
      case ($urandom_range(0, 2))
        0:       bias = 85;
        1:       bias = 20;
        default: bias = 50;
      endcase
      repeat (seg) begin
        if ($urandom_range(0, 99) < bias) begin
          v = pick_value();
          value_pool.push_back(v);
          if (value_pool.size() > 64) void'(value_pool.pop_front());
          send_op(1'b0, v);
        end else begin
          // mostly delete something that was inserted, otherwise a likely miss
          if (value_pool.size() > 0 && $urandom_range(0, 99) < 65) begin
            k = $urandom_range(0, value_pool.size() - 1);
            v = value_pool[k];
            value_pool.delete(k);
          end else begin
            v = pick_value();
          end
          send_op(1'b1, v);
        end
      end
      left -= seg;
    end
  endtask

  initial begin
    start    = 1'b0;
    op       = 1'b0;
    value    = '0;
    rst      = 1'b1;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty delete, extremes, duplicates, misses, full table
    send_op(1'b1, 32'd5);
    send_op(1'b0, 32'h7fff_ffff);
    send_op(1'b0, 32'h8000_0000);
    send_op(1'b0, 32'h0000_0000);
    send_op(1'b0, 32'hffff_ffff);
    send_op(1'b0, 32'h0000_0000);
    send_op(1'b1, 32'h0000_0000);
    send_op(1'b1, 32'd5);
    send_op(1'b1, 32'h8000_0000);
    send_op(1'b1, 32'h7fff_ffff);
    repeat (14) send_op(1'b0, $urandom);
    send_op(1'b0, 32'd7);
    send_op(1'b1, 32'd12345);
    send_op(1'b1, 32'hffff_ffff);

    // Random traffic under three sender pacing mixes
    run_phase(0, 370);
    run_phase(79, 370);
    run_phase(16, 370);
    start <= 1'b0;

    // Drain, then allow a late or extra strobe to show up
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("Covered %0d inserts and %0d deletes at 0, 79 and 16 percent sender idle",
             n_ins, n_del);
    $display("Checked %0d results: %0d full refusals, %0d empty deletes, %0d misses",
             checked, full_hits, empty_hits, miss_hits);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/slid_pkg.sv
hw/rtl/slid_ram.sv
hw/rtl/slid_datapath.sv
hw/rtl/slid_ctrl.sv
hw/rtl/sorted_list_insert_delete.sv
tb/slid_checker.sv
tb/tb_sorted_list_insert_delete.sv
